// ===== rtl/glow_window_sum_blend_top_defines.svh =====
// Assertion macros shared by the glow window sum blend RTL.
`ifndef GLOW_WINDOW_SUM_BLEND_TOP_DEFINES_SVH
`define GLOW_WINDOW_SUM_BLEND_TOP_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define GWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define GWS_ASSERT_NEVER(lbl, expr, msg) \
    `GWS_ASSERT(lbl, !(expr), msg)
`else
`define GWS_ASSERT(lbl, prop, msg)
`define GWS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/gws_pkg.sv =====
// Package with constants and types of the glow window sum blend block.
package gws_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int SEEN_W     = 11;
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 32;
    localparam int HIST_W     = 3 * PIX_W;
    localparam int CMP_W      = (LEN_W > ADDR_W + 1) ? LEN_W : ADDR_W + 1;
    localparam int SUB_W      = (SEEN_W > CMP_W) ? SEEN_W : CMP_W;

    localparam logic [SEEN_W-1:0] COUNT_MAX = '1;

    localparam logic signed [SUM_W-1:0] CLAMP_LUMA = 32'sh2000;
    localparam logic [PIX_W-1:0]        CLAMP_Y16  = 16'h2000;
    localparam int CHROMA_SHIFT = 13;
    localparam int PRE_SHIFT    = 4;
    localparam int POST_SHIFT   = 10;

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_GAIN       = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_BLEND,
        ST_DIV,
        ST_OUT
    } gws_state_t;

endpackage

// ===== rtl/gws_stream_if.sv =====
// Stream interfaces for input samples and blended output pixels.
interface gws_sample_if;
    logic                                valid;
    logic                                ready;
    logic                                line_start;
    logic                                sample_valid;
    logic signed [gws_pkg::PIX_W-1:0]    sample_y;
    logic signed [gws_pkg::PIX_W-1:0]    sample_cb;
    logic signed [gws_pkg::PIX_W-1:0]    sample_cr;
    logic                                emit;
    logic signed [gws_pkg::PIX_W-1:0]    dst_y;
    logic signed [gws_pkg::PIX_W-1:0]    dst_cb;
    logic signed [gws_pkg::PIX_W-1:0]    dst_cr;

    modport source (
        output valid, line_start, sample_valid, sample_y, sample_cb, sample_cr,
               emit, dst_y, dst_cb, dst_cr,
        input  ready
    );
    modport sink (
        input  valid, line_start, sample_valid, sample_y, sample_cb, sample_cr,
               emit, dst_y, dst_cb, dst_cr,
        output ready
    );
endinterface

interface gws_pixel_if;
    logic                                valid;
    logic                                ready;
    logic signed [gws_pkg::PIX_W-1:0]    out_y;
    logic signed [gws_pkg::PIX_W-1:0]    out_cb;
    logic signed [gws_pkg::PIX_W-1:0]    out_cr;
    logic                                luma_clamped;

    modport source (
        output valid, out_y, out_cb, out_cr, luma_clamped,
        input  ready
    );
    modport sink (
        input  valid, out_y, out_cb, out_cr, luma_clamped,
        output ready
    );
endinterface

// ===== rtl/gws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/glow_window_sum_blend_top.sv =====
// Top level of the glow window sum blend block: window sums, scaling, blend and clamp.
//
// Sliding-window Y/Cb/Cr box sum with glow blend. Items are handled one at a time:
// an item without emit is accepted with the history read/write, then the sum is
// updated once the history RAM returns the leaving sample. An emit item adds a
// multiply state, a blend state and an output load state. When the blended luma
// exceeds 0x2000 the two chroma quotients come from a restoring divider that
// retires one bit a cycle. A finished pixel sits in the output register while the
// next item is taken; only a new result meeting a full, stalled output register
// waits. The history RAM needs no clearing after reset.
`include "glow_window_sum_blend_top_defines.svh"

module glow_window_sum_blend_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gws_pkg::PADDR_W-1:0] paddr,
    input  logic [gws_pkg::PDATA_W-1:0] pwdata,
    output logic [gws_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    gws_sample_if.sink                  sample_ch,
    gws_pixel_if.source                 pixel_ch
);

    localparam int AW  = gws_pkg::ADDR_W;
    localparam int PW  = gws_pkg::PIX_W;
    localparam int SW  = gws_pkg::SUM_W;
    localparam int CW  = gws_pkg::CMP_W;

    gws_pkg::gws_state_t state_reg, state_next;

    logic [gws_pkg::LEN_W-1:0]  window_len_reg;
    logic [gws_pkg::GAIN_W-1:0] gain_reg;

    logic signed [SW-1:0] sum_y_reg, sum_cb_reg, sum_cr_reg;
    logic [gws_pkg::SEEN_W-1:0] seen_reg;
    logic [AW-1:0] wp_reg;

    logic signed [PW-1:0] ey_reg, ecb_reg, ecr_reg;
    logic signed [PW-1:0] dy_reg, dcb_reg, dcr_reg;
    logic sub_reg, emit_reg;

    logic signed [SW-1:0] prod_y_reg, prod_cb_reg, prod_cr_reg;
    logic signed [SW-1:0] blend_y_reg, blend_cb_reg, blend_cr_reg;
    logic clamp_reg;

    logic [SW-1:0] div_num_reg [2];
    logic [SW-1:0] div_rem_reg [2];
    logic          div_neg_reg [2];
    logic [gws_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic out_valid_reg;
    logic signed [PW-1:0] out_y_reg, out_cb_reg, out_cr_reg;
    logic out_clamp_reg;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            gws_pkg::REG_GAIN:       prdata = gws_pkg::PDATA_W'(gain_reg);
            gws_pkg::REG_WINDOW_LEN: prdata = gws_pkg::PDATA_W'(window_len_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= gws_pkg::LEN_W'(1);
            gain_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == gws_pkg::REG_GAIN)
            begin
                gain_reg <= pwdata[gws_pkg::GAIN_W-1:0];
            end
            else
            begin
                window_len_reg <= pwdata[gws_pkg::LEN_W-1:0];
            end
        end
    end

    // ---------------- window addressing ----------------
    logic [CW-1:0] len_raw, len_eff, wp_ext, lp_ext;
    logic [AW-1:0] lp, wp_inc;
    logic [gws_pkg::SEEN_W-1:0] seen_eff;
    logic sub_now;
    logic in_acc;

    assign in_acc = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == gws_pkg::ST_IDLE);

    always_comb
    begin
        len_raw = CW'(window_len_reg);
        if (len_raw == '0)
        begin
            len_eff = CW'(1);
        end
        else if (len_raw > CW'(gws_pkg::MAX_WINDOW))
        begin
            len_eff = CW'(gws_pkg::MAX_WINDOW);
        end
        else
        begin
            len_eff = len_raw;
        end
        wp_ext = CW'(wp_reg);
        if (wp_ext >= len_eff)
        begin
            lp_ext = wp_ext - len_eff;
        end
        else
        begin
            lp_ext = wp_ext + CW'(gws_pkg::MAX_WINDOW) - len_eff;
        end
        lp = lp_ext[AW-1:0];
        wp_inc = (wp_reg == AW'(gws_pkg::MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
        seen_eff = sample_ch.line_start ? '0 : seen_reg;
        sub_now = gws_pkg::SUB_W'(seen_eff) >= gws_pkg::SUB_W'(len_eff);
    end

    // ---------------- history RAM ----------------
    logic signed [PW-1:0] in_y, in_cb, in_cr;
    logic [gws_pkg::HIST_W-1:0] hist_rd;

    assign in_y  = sample_ch.sample_valid ? sample_ch.sample_y  : '0;
    assign in_cb = sample_ch.sample_valid ? sample_ch.sample_cb : '0;
    assign in_cr = sample_ch.sample_valid ? sample_ch.sample_cr : '0;

    gws_ram #(
        .WIDTH (gws_pkg::HIST_W),
        .DEPTH (gws_pkg::MAX_WINDOW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (in_acc),
        .waddr (wp_reg),
        .wdata ({in_y, in_cb, in_cr}),
        .raddr (lp),
        .rdata (hist_rd)
    );

    // ---------------- datapath combinational ----------------
    logic signed [SW-1:0] lv_y, lv_cb, lv_cr;
    logic signed [SW-1:0] mul_y, mul_cb, mul_cr;
    logic signed [SW-1:0] bl_y, bl_cb, bl_cr;
    logic signed [SW-1:0] num_cb, num_cr;
    logic [SW-1:0] div_src [2];
    logic [SW-1:0] div_mag [2];
    logic [SW-1:0] div_num_step [2];
    logic [SW-1:0] div_rem_step [2];
    logic [SW:0]   rem_sh [2];
    logic [SW:0]   rem_diff [2];
    logic [SW-1:0] quot [2];
    logic signed [gws_pkg::GAIN_W:0] gain_s;
    logic out_load;

    always_comb
    begin
        lv_y  = sub_reg ? SW'($signed(hist_rd[3*PW-1:2*PW])) : '0;
        lv_cb = sub_reg ? SW'($signed(hist_rd[2*PW-1:PW]))   : '0;
        lv_cr = sub_reg ? SW'($signed(hist_rd[PW-1:0]))      : '0;

        // shift right 4 then gain; low 32 bits of the product
        gain_s = $signed({1'b0, gain_reg});
        mul_y  = SW'($signed(sum_y_reg[SW-1:gws_pkg::PRE_SHIFT])  * gain_s);
        mul_cb = SW'($signed(sum_cb_reg[SW-1:gws_pkg::PRE_SHIFT]) * gain_s);
        mul_cr = SW'($signed(sum_cr_reg[SW-1:gws_pkg::PRE_SHIFT]) * gain_s);

        bl_y  = SW'($signed(prod_y_reg[SW-1:gws_pkg::POST_SHIFT]))  + SW'(dy_reg);
        bl_cb = SW'($signed(prod_cb_reg[SW-1:gws_pkg::POST_SHIFT])) + SW'(dcb_reg);
        bl_cr = SW'($signed(prod_cr_reg[SW-1:gws_pkg::POST_SHIFT])) + SW'(dcr_reg);

        num_cb = {bl_cb[SW-1-gws_pkg::CHROMA_SHIFT:0], {gws_pkg::CHROMA_SHIFT{1'b0}}};
        num_cr = {bl_cr[SW-1-gws_pkg::CHROMA_SHIFT:0], {gws_pkg::CHROMA_SHIFT{1'b0}}};
        div_src[0] = num_cb;
        div_src[1] = num_cr;

        // one restoring step per lane; divisor is the positive blended luma
        for (int i = 0; i < 2; i++)
        begin
            div_mag[i]  = div_src[i][SW-1] ? (~div_src[i] + 1'b1) : div_src[i];
            rem_sh[i]   = {div_rem_reg[i], div_num_reg[i][SW-1]};
            rem_diff[i] = rem_sh[i] - {1'b0, blend_y_reg};
            if (!rem_diff[i][SW])
            begin
                div_rem_step[i] = rem_diff[i][SW-1:0];
                div_num_step[i] = {div_num_reg[i][SW-2:0], 1'b1};
            end
            else
            begin
                div_rem_step[i] = rem_sh[i][SW-1:0];
                div_num_step[i] = {div_num_reg[i][SW-2:0], 1'b0};
            end
            quot[i] = div_neg_reg[i] ? (~div_num_reg[i] + 1'b1) : div_num_reg[i];
        end

        out_load = (state_reg == gws_pkg::ST_OUT) && (!out_valid_reg || pixel_ch.ready);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gws_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gws_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = gws_pkg::ST_UPDATE;
                end
            end
            gws_pkg::ST_UPDATE:
            begin
                state_next = emit_reg ? gws_pkg::ST_MUL : gws_pkg::ST_IDLE;
            end
            gws_pkg::ST_MUL:
            begin
                state_next = gws_pkg::ST_BLEND;
            end
            gws_pkg::ST_BLEND:
            begin
                state_next = (bl_y > gws_pkg::CLAMP_LUMA) ? gws_pkg::ST_DIV : gws_pkg::ST_OUT;
            end
            gws_pkg::ST_DIV:
            begin
                if (div_cnt_reg == gws_pkg::DIV_CNT_W'(gws_pkg::DIV_STEPS - 1))
                begin
                    state_next = gws_pkg::ST_OUT;
                end
            end
            gws_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = gws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gws_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- window state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_y_reg  <= '0;
            sum_cb_reg <= '0;
            sum_cr_reg <= '0;
            seen_reg   <= '0;
            wp_reg     <= '0;
        end
        else if (in_acc && sample_ch.line_start)
        begin
            sum_y_reg  <= '0;
            sum_cb_reg <= '0;
            sum_cr_reg <= '0;
            seen_reg   <= '0;
        end
        else if (state_reg == gws_pkg::ST_UPDATE)
        begin
            sum_y_reg  <= sum_y_reg  - lv_y  + SW'(ey_reg);
            sum_cb_reg <= sum_cb_reg - lv_cb + SW'(ecb_reg);
            sum_cr_reg <= sum_cr_reg - lv_cr + SW'(ecr_reg);
            wp_reg     <= wp_inc;
            if (seen_reg != gws_pkg::COUNT_MAX)
            begin
                seen_reg <= seen_reg + 1'b1;
            end
        end
    end

    // ---------------- item payload and arithmetic ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ey_reg   <= in_y;
            ecb_reg  <= in_cb;
            ecr_reg  <= in_cr;
            dy_reg   <= sample_ch.dst_y;
            dcb_reg  <= sample_ch.dst_cb;
            dcr_reg  <= sample_ch.dst_cr;
            sub_reg  <= sub_now;
            emit_reg <= sample_ch.emit;
        end
        if (state_reg == gws_pkg::ST_MUL)
        begin
            prod_y_reg  <= mul_y;
            prod_cb_reg <= mul_cb;
            prod_cr_reg <= mul_cr;
        end
        if (state_reg == gws_pkg::ST_BLEND)
        begin
            blend_y_reg  <= bl_y;
            blend_cb_reg <= bl_cb;
            blend_cr_reg <= bl_cr;
            clamp_reg    <= bl_y > gws_pkg::CLAMP_LUMA;
        end
    end

    // divider lanes: numerator magnitude and sign are loaded in the blend state, ahead of
    // the first step, then one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == gws_pkg::ST_BLEND)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == gws_pkg::ST_DIV)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (state_reg == gws_pkg::ST_DIV)
            begin
                div_num_reg[i] <= div_num_step[i];
                div_rem_reg[i] <= div_rem_step[i];
            end
            if (state_reg == gws_pkg::ST_BLEND)
            begin
                div_neg_reg[i] <= div_src[i][SW-1];
                div_num_reg[i] <= div_mag[i];
                div_rem_reg[i] <= '0;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_clamp_reg <= clamp_reg;
            if (clamp_reg)
            begin
                out_y_reg  <= gws_pkg::CLAMP_Y16;
                out_cb_reg <= quot[0][PW-1:0];
                out_cr_reg <= quot[1][PW-1:0];
            end
            else
            begin
                out_y_reg  <= blend_y_reg[PW-1:0];
                out_cb_reg <= blend_cb_reg[PW-1:0];
                out_cr_reg <= blend_cr_reg[PW-1:0];
            end
        end
    end

    assign pixel_ch.valid        = out_valid_reg;
    assign pixel_ch.out_y        = out_y_reg;
    assign pixel_ch.out_cb       = out_cb_reg;
    assign pixel_ch.out_cr       = out_cr_reg;
    assign pixel_ch.luma_clamped = out_clamp_reg;

    // ---------------- assertions ----------------
    `GWS_ASSERT(a_div_needs_clamp, (state_reg == gws_pkg::ST_DIV) |-> clamp_reg, "divider running without luma clamp")
    `GWS_ASSERT(a_out_from_seq, $rose(out_valid_reg) |-> $past(state_reg == gws_pkg::ST_OUT), "output beat not loaded by sequencer")
    `GWS_ASSERT(a_clamp_luma, (pixel_ch.valid && pixel_ch.luma_clamped) |-> (pixel_ch.out_y == gws_pkg::CLAMP_Y16), "clamped beat with wrong luma")
    `GWS_ASSERT(a_seen_grows, (state_reg == gws_pkg::ST_UPDATE) |=> (seen_reg != '0), "sample count wrapped")
    `GWS_ASSERT_NEVER(a_sub_fresh_line, (state_reg == gws_pkg::ST_UPDATE) && sub_reg && (seen_reg == '0), "leaving sample subtracted on a fresh line")

endmodule
